// ===== hdl/sxfs_pkg.sv =====
// sxfs_pkg: shared types, command codes and constants for the sprite xor frame store
// no dependencies
`default_nettype none
package sxfs_pkg;
	localparam int FRAME_WIDTH_DEF  = 128;
	localparam int FRAME_HEIGHT_DEF = 64;
	localparam int ROT_STEP         = 4;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_LORES  = 3'd1;
	localparam logic [2:0] CMD_HIRES  = 3'd2;
	localparam logic [2:0] CMD_DRAW   = 3'd3;
	localparam logic [2:0] CMD_ROTL   = 3'd4;
	localparam logic [2:0] CMD_ROTR   = 3'd5;
	localparam logic [2:0] CMD_SCROLL = 3'd6;
	localparam logic [2:0] CMD_READ   = 3'd7;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] bits;
		logic        first_row;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [3:0]  scroll_rows;
	} req_t;
endpackage
`default_nettype wire

// ===== hdl/sxfs_front.sv =====
// sxfs_front: accepts requests, normalises sprite bits, and queues them for the back end
// depends on sxfs_pkg
`default_nettype none
module sxfs_front
	import sxfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] row_data,
	input  wire logic        wide_row,
	input  wire logic        first_row,
	input  wire logic [7:0]  x_pos,
	input  wire logic [7:0]  y_pos,
	input  wire logic [3:0]  scroll_rows,
	output logic             q_valid,
	output req_t             q_req,
	input  wire logic        q_pop
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	req_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            push;
	req_t            in_req;

	assign busy    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_req   = slot_q[rd_q];

	// narrow rows sit in the top byte, left aligned
	always_comb begin
		in_req.command     = command;
		in_req.bits        = wide_row ? row_data : {row_data[7:0], 8'h00};
		in_req.first_row   = first_row;
		in_req.x_pos       = x_pos;
		in_req.y_pos       = y_pos;
		in_req.scroll_rows = scroll_rows;
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)  wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sxfs_back.sv =====
// sxfs_back: frame memory and the sequencer that carries out queued requests
// depends on sxfs_pkg
`default_nettype none
module sxfs_back
	import sxfs_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  req_t             q_req,
	output logic             q_pop,
	output logic             done,
	output logic             collision,
	output logic [15:0]      pixels,
	output logic             hires_now
);
	localparam int W  = FRAME_WIDTH;
	localparam int H  = FRAME_HEIGHT;
	localparam int YW = $clog2(H);
	localparam int XW = $clog2(W);
	localparam int HW = W / 2;
	localparam int WP = W + 16;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RMW   = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_SWR   = 3'd3;
	localparam logic [2:0] ST_INIT  = 3'd4;

	logic [W-1:0]  mem [H];
	logic [W-1:0]  rd_data_q;
	logic [2:0]    state_q;
	req_t          cur_q;
	logic [YW:0]   idx_q;
	logic          hires_q, coll_q;
	logic [YW:0]   act_h;
	logic [YW-1:0] row_sel;
	logic [YW-1:0] row_in;
	logic [XW-1:0] xm;
	logic [YW:0]   src_row;

	// memory port signals
	logic          we;
	logic [YW-1:0] waddr, raddr;
	logic [W-1:0]  wdata;

	assign act_h   = hires_q ? (YW+1)'(H) : (YW+1)'(H/2);
	assign row_sel = hires_q ? cur_q.y_pos[YW-1:0] : {1'b0, cur_q.y_pos[YW-2:0]};
	assign row_in  = hires_q ? q_req.y_pos[YW-1:0] : {1'b0, q_req.y_pos[YW-2:0]};
	assign xm      = hires_q ? cur_q.x_pos[XW-1:0] : {1'b0, cur_q.x_pos[XW-2:0]};
	assign src_row = idx_q - (YW+1)'(cur_q.scroll_rows);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_q <= mem[raddr];
	end

	// row word in; a 16-wide window of pixels starting at xm, the mask for draw and the rotated row out
	logic [WP-1:0] ext_row;
	logic [15:0]   window;
	logic [W-1:0]  mask_full;
	logic [2*W-1:0] mask_dbl;
	logic [W-1:0]  mask_lo;
	logic [W-1:0]  rot_row;
	logic [W-1:0]  rmw_row;

	always_comb begin
		// pixel column c lives at bit W-1-c
		if (hires_q) ext_row = {rd_data_q, rd_data_q[W-1 -: 16]};
		else ext_row = {rd_data_q[W-1 -: HW], rd_data_q[W-1 -: HW], rd_data_q[W-1 -: 16]};
		window = 16'(ext_row >> (WP - 16 - int'(xm)));

		mask_lo   = '0;
		mask_dbl  = {cur_q.bits, (2*W-16)'(0)} >> xm;
		if (hires_q) mask_full = mask_dbl[2*W-1 -: W] | mask_dbl[W-1:0];
		else begin
			mask_lo   = mask_dbl[2*W-1 -: W] | (mask_dbl[2*W-1 -: W] << HW);
			mask_full = {mask_lo[W-1 -: HW], (W-HW)'(0)};
		end

		if (hires_q) begin
			if (cur_q.command == CMD_ROTL)
				rot_row = {rd_data_q[W-1-ROT_STEP:0], rd_data_q[W-1 -: ROT_STEP]};
			else
				rot_row = {rd_data_q[ROT_STEP-1:0], rd_data_q[W-1:ROT_STEP]};
		end else begin
			if (cur_q.command == CMD_ROTL)
				rot_row = {rd_data_q[W-1-ROT_STEP -: HW-ROT_STEP],
					rd_data_q[W-1 -: ROT_STEP], (W-HW)'(0)};
			else
				rot_row = {rd_data_q[W-HW+ROT_STEP-1 -: ROT_STEP],
					rd_data_q[W-1 -: HW-ROT_STEP], (W-HW)'(0)};
		end
		rmw_row = (cur_q.command == CMD_DRAW) ? (rd_data_q ^ mask_full) : rot_row;
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[YW-1:0];
		wdata = '0;
		raddr = row_sel;
		unique case (state_q)
			ST_INIT: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				raddr = row_in;
			end
			ST_RMW: begin
				if (cur_q.command == CMD_DRAW) begin
					we    = 1'b1;
					waddr = row_sel;
					wdata = rmw_row;
				end
			end
			ST_SWEEP: begin
				raddr = idx_q[YW-1:0];
				if (cur_q.command == CMD_SCROLL) raddr = src_row[YW-1:0];
			end
			ST_SWR: begin
				we = 1'b1;
				unique case (cur_q.command)
					CMD_ROTL, CMD_ROTR: wdata = rmw_row;
					CMD_SCROLL: wdata = (idx_q >= (YW+1)'(cur_q.scroll_rows)) ? rd_data_q : '0;
					default: wdata = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) cur_q <= q_req;
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			idx_q     <= '0;
			hires_q   <= 1'b0;
			coll_q    <= 1'b0;
			done      <= 1'b0;
			pixels    <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (YW+1)'(H-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_req.command)
							CMD_DRAW, CMD_READ: state_q <= ST_RMW;
							CMD_LORES, CMD_HIRES, CMD_CLEAR: begin
								if (q_req.command == CMD_LORES) hires_q <= 1'b0;
								if (q_req.command == CMD_HIRES) hires_q <= 1'b1;
								idx_q   <= '0;
								state_q <= ST_INIT;
								done    <= 1'b1;
								pixels  <= '0;
							end
							CMD_SCROLL: begin
								if (q_req.scroll_rows == '0) begin
									done   <= 1'b1;
									pixels <= '0;
								end else begin
									idx_q   <= act_h - 1'b1;
									state_q <= ST_SWEEP;
								end
							end
							default: begin
								idx_q   <= '0;
								state_q <= ST_SWEEP;
							end
						endcase
					end
				end
				ST_RMW: begin
					if (cur_q.command == CMD_DRAW) begin
						if (cur_q.first_row) coll_q <= |(rd_data_q & mask_full);
						else coll_q <= coll_q | (|(rd_data_q & mask_full));
						pixels <= '0;
					end else pixels <= window;
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: state_q <= ST_SWR;
				ST_SWR: begin
					if (cur_q.command == CMD_SCROLL) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
							done    <= 1'b1;
							pixels  <= '0;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= ST_SWEEP;
						end
					end else if (idx_q == act_h - 1'b1) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
						pixels  <= '0;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SWEEP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign collision = coll_q;
	assign hires_now = hires_q;
endmodule
`default_nettype wire

// ===== hdl/sprite_xor_frame_store.sv =====
// sprite_xor_frame_store: top level, front queue plus back end sequencer and frame memory
// depends on sxfs_pkg, sxfs_front, sxfs_back
//
// channel   direction  handshake       payload
// request   in         start & !busy   command row_data wide_row first_row x_pos y_pos scroll_rows
// result    out        done strobe     collision pixels hires_now
//
// draw and read: a row read, then a modify and write (draw) or a pixel window result (read).
// clear and mode change sweep all FRAME_HEIGHT rows, one a cycle, after the result.
// rotate and scroll take a read state then a write state per active row (ST_SWEEP, ST_SWR).
// after reset the memory is cleared row by row; requests queue meanwhile.
// a two-entry queue decouples acceptance; busy rises only when it is full.
`default_nettype none
module sprite_xor_frame_store
	import sxfs_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] row_data,
	input  wire logic        wide_row,
	input  wire logic        first_row,
	input  wire logic [7:0]  x_pos,
	input  wire logic [7:0]  y_pos,
	input  wire logic [3:0]  scroll_rows,
	output logic             done,
	output logic             collision,
	output logic [15:0]      pixels,
	output logic             hires_now
);
	logic q_valid, q_pop;
	req_t q_req;

	sxfs_front u_front (
		.clk, .arst_n, .start, .busy, .command, .row_data, .wide_row, .first_row,
		.x_pos, .y_pos, .scroll_rows, .q_valid, .q_req, .q_pop
	);

	sxfs_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
		.clk, .arst_n, .q_valid, .q_req, .q_pop, .done, .collision, .pixels, .hires_now
	);
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for sprite_xor_frame_store, predicts every result of
// a request from a local frame image and compares it with the done strobe outputs
// depends on sxfs_pkg and sprite_xor_frame_store
`default_nettype none
module tb_top;
	import sxfs_pkg::*;

	localparam int FW = FRAME_WIDTH_DEF;
	localparam int FH = FRAME_HEIGHT_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [2:0]  command;
		logic [15:0] row_data;
		logic        wide_row;
		logic        first_row;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [3:0]  scroll_rows;
	} request_t;

	typedef struct {
		logic        collision;
		logic [15:0] pixels;
		logic        hires_now;
	} screen_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] command = CMD_CLEAR;
	logic [15:0] row_data = '0;
	logic wide_row = 1'b0;
	logic first_row = 1'b0;
	logic [7:0] x_pos = '0;
	logic [7:0] y_pos = '0;
	logic [3:0] scroll_rows = '0;
	logic done;
	logic collision;
	logic [15:0] pixels;
	logic hires_now;

	request_t pending_requests[$];
	screen_result_t expected_results[$];
	logic frame_image[FH][FW];
	logic hires_model = 1'b0;
	logic collision_model = 1'b0;
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit stimulus_done = 1'b0;

	sprite_xor_frame_store dut (.*);

	always #5 clk = ~clk;

	function automatic screen_result_t predict_screen(request_t r);
		screen_result_t res;
		int w, h, row, col, n, cnt;
		logic [15:0] bits;
		logic line_copy[FW];
		w = hires_model ? FW : FW / 2;
		h = hires_model ? FH : FH / 2;
		res.pixels = '0;
		case (r.command)
			CMD_CLEAR: begin
				foreach (frame_image[y, x]) frame_image[y][x] = 1'b0;
			end
			CMD_LORES, CMD_HIRES: begin
				hires_model = (r.command == CMD_HIRES);
				foreach (frame_image[y, x]) frame_image[y][x] = 1'b0;
			end
			CMD_DRAW: begin
				if (r.first_row)
					collision_model = 1'b0;
				cnt = r.wide_row ? 16 : 8;
				bits = r.wide_row ? r.row_data : {8'h00, r.row_data[7:0]};
				row = r.y_pos % h;
				for (int i = 0; i < cnt; i++) begin
					col = (r.x_pos + i) % w;
					if (bits[cnt-1-i]) begin
						if (frame_image[row][col])
							collision_model = 1'b1;
						frame_image[row][col] = ~frame_image[row][col];
					end
				end
			end
			CMD_ROTL, CMD_ROTR: begin
				for (int y = 0; y < h; y++) begin
					for (int x = 0; x < w; x++)
						line_copy[x] = frame_image[y][(r.command == CMD_ROTL) ?
							(x + ROT_STEP) % w : (x + w - ROT_STEP) % w];
					for (int x = 0; x < w; x++) frame_image[y][x] = line_copy[x];
				end
			end
			CMD_SCROLL: begin
				n = r.scroll_rows;
				if (n != 0) begin
					for (int y = h - 1; y >= 0; y--)
						for (int x = 0; x < w; x++)
							frame_image[y][x] = (y >= n) ? frame_image[y-n][x] : 1'b0;
				end
			end
			default: begin
				row = r.y_pos % h;
				for (int i = 0; i < 16; i++)
					res.pixels[15-i] = frame_image[row][((r.x_pos % w) + i) % w];
			end
		endcase
		res.collision = collision_model;
		res.hires_now = hires_model;
		return res;
	endfunction

	function automatic request_t make_request(logic [2:0] cmd);
		request_t r;
		r.command = cmd;
		r.row_data = 16'($urandom);
		r.wide_row = 1'($urandom);
		r.first_row = 1'($urandom);
		r.x_pos = 8'($urandom);
		r.y_pos = 8'($urandom);
		r.scroll_rows = 4'($urandom);
		return r;
	endfunction

	task automatic queue_request(logic [2:0] cmd, logic [15:0] d, logic wd, logic fr,
		logic [7:0] xp, logic [7:0] yp, logic [3:0] sr);
		request_t r;
		r = '{cmd, d, wd, fr, xp, yp, sr};
		pending_requests.push_back(r);
	endtask

	initial begin
		request_t r;
		int pick;
		foreach (frame_image[y, x]) frame_image[y][x] = 1'b0;
		// directed: extremes, wrap, collisions, mode clears, scrolls
		queue_request(CMD_READ, 16'h0000, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_DRAW, 16'hFFFF, 1'b0, 1'b1, 8'd60, 8'd31, 4'd0);
		queue_request(CMD_DRAW, 16'h00F0, 1'b0, 1'b0, 8'd60, 8'd31, 4'd0);
		queue_request(CMD_READ, 16'h0000, 1'b0, 1'b1, 8'd56, 8'd31, 4'd0);
		queue_request(CMD_DRAW, 16'hA5C3, 1'b1, 1'b1, 8'd255, 8'd255, 4'd15);
		queue_request(CMD_READ, 16'hFFFF, 1'b1, 1'b0, 8'd255, 8'd255, 4'd0);
		queue_request(CMD_ROTL, 16'h0, 1'b0, 1'b1, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_READ, 16'h0, 1'b0, 1'b0, 8'd0, 8'd31, 4'd0);
		queue_request(CMD_ROTR, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_SCROLL, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_SCROLL, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd1);
		queue_request(CMD_READ, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_CLEAR, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_HIRES, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_DRAW, 16'h8001, 1'b1, 1'b1, 8'd120, 8'd63, 4'd0);
		queue_request(CMD_READ, 16'h0, 1'b0, 1'b0, 8'd127, 8'd63, 4'd0);
		queue_request(CMD_SCROLL, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd15);
		queue_request(CMD_HIRES, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_DRAW, 16'hFF00, 1'b1, 1'b1, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_DRAW, 16'h0080, 1'b0, 1'b1, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_LORES, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_LORES, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd0);
		queue_request(CMD_SCROLL, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0, 4'd14);
		// random: mostly draws and reads so the screen fills up
		for (int i = 0; i < 1000; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) r = make_request(CMD_DRAW);
			else if (pick < 75) r = make_request(CMD_READ);
			else if (pick < 80) r = make_request(CMD_ROTL);
			else if (pick < 85) r = make_request(CMD_ROTR);
			else if (pick < 92) r = make_request(CMD_SCROLL);
			else if (pick < 94) r = make_request(CMD_CLEAR);
			else if (pick < 96) r = make_request(CMD_LORES);
			else if (pick < 98) r = make_request(CMD_HIRES);
			else r = make_request(3'($urandom));
			pending_requests.push_back(r);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: bursts separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_screen(pending_requests.pop_front()));
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				request_t r;
				r = pending_requests[0];
				start <= 1'b1;
				command <= r.command;
				row_data <= r.row_data;
				wide_row <= r.wide_row;
				first_row <= r.first_row;
				x_pos <= r.x_pos;
				y_pos <= r.y_pos;
				scroll_rows <= r.scroll_rows;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 20);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end
			end else begin
				start <= 1'b0;
				stimulus_done <= 1'b1;
			end
		end
	end

	// monitor: results cannot be held off
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					screen_result_t e;
					e = expected_results.pop_front();
					if (collision !== e.collision) begin
						$error("collision expected %0h actual %0h", e.collision, collision);
						errors++;
					end
					if (pixels !== e.pixels) begin
						$error("pixels expected %0h actual %0h", e.pixels, pixels);
						errors++;
					end
					if (hires_now !== e.hires_now) begin
						$error("hires_now expected %0h actual %0h", e.hires_now, hires_now);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		while (!(stimulus_done && !start && expected_results.size() == 0)
			&& idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (300) @(posedge clk);
			if (errors == 0 && expected_results.size() == 0 && !done)
				$display("TEST PASSED");
			else
				$display("TEST FAILED");
			$finish;
		end
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/sxfs_pkg.sv
hdl/sxfs_front.sv
hdl/sxfs_back.sv
hdl/sprite_xor_frame_store.sv
bench/tb_top.sv
